>>> design/swap_timing_lock_detector_unit_assert.svh
// Assertion macros for the swap lock detector checker.
`ifndef SWAP_TIMING_LOCK_DETECTOR_UNIT_ASSERT_SVH
`define SWAP_TIMING_LOCK_DETECTOR_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define STLD_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stld assertion failed");

// Next-cycle implication, clocked on clk, off while arst_n is low.
`define STLD_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stld assertion failed");

`endif

>>> design/stld_pkg.sv
// Package: widths, codes, command/status types and helpers of the swap lock detector.
`default_nettype none
package stld_pkg;

	localparam int MAX_WINDOW = 16;
	localparam int IDX_W      = $clog2(MAX_WINDOW);
	localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
	localparam int NUM_W      = 32;
	localparam int TIME_W     = 48;
	localparam int OUT_W      = 48;
	localparam int SLOPE_FRAC = 16;
	localparam int REQ_W      = 5;
	localparam int PER_W      = 32;
	localparam int ADV_W      = 8;
	localparam int CFG_W      = 32;
	localparam int REG_IDX_W  = 3;
	localparam int ACC_W      = 112;
	localparam int MB_W       = 40;
	localparam int DIG_W      = 8;
	localparam int MB_DIG     = (MB_W + DIG_W - 1) / DIG_W;
	localparam int MCNT_W     = $clog2(MB_DIG);
	localparam int DCNT_W     = $clog2(ACC_W);
	localparam int SX_W       = NUM_W + IDX_W + 2;
	localparam int SY_W       = TIME_W + IDX_W + 2;
	localparam int RADV_W     = CNT_W + ADV_W;
	localparam int TST_W      = TIME_W + 3;

	typedef logic signed [ACC_W-1:0] acc_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_REQ_SWAPS, REG_NOMINAL, REG_TOLERANCE, REG_ADVANCE,
		REG_EN_INTERVAL, REG_EN_USER, REG_EN_SLOPE, REG_EN_MODEL_PRED
	} reg_idx_t;

	typedef enum logic [2:0] {
		MOP_DYDX, MOP_DXDX, MOP_RSXY, MOP_SXSY, MOP_RSXX, MOP_SXSX, MOP_RADV, MOP_SLOPE
	} mop_t;

	typedef enum logic {DOP_SLOPE, DOP_EST} dop_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CHECK, ST_SUM_RD, ST_SUM_DAT, ST_MUL_GO, ST_MUL_WAIT, ST_DEN_CHK,
		ST_DIV_GO, ST_DIV_WAIT, ST_EST_WR, ST_T_RD, ST_T_CHK, ST_OUT
	} state_t;

	typedef struct packed {
		logic [REQ_W-1:0] req_swaps;
		logic [PER_W-1:0] nominal;
		logic [PER_W-1:0] tolerance;
		logic [ADV_W-1:0] advance;
		logic             en_interval;
		logic             en_user;
		logic             en_slope;
		logic             en_model_pred;
	} cfg_t;

	typedef struct packed {
		logic accept;
		logic clr_sums;
		logic sum_dat;
		logic mul_start;
		mop_t mop;
		logic div_start;
		dop_t dop;
		logic est_wr;
		logic t_init;
		logic t_chk;
		logic inc_k;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic den_zero;
		logic k_sum_last;
		logic k_t_last;
		logic mul_done;
		logic div_done;
		logic out_free;
	} sts_t;

	function automatic logic [CNT_W-1:0] win_len(input logic [REQ_W-1:0] req);
		logic [CNT_W-1:0] r;
		if (int'(req) < 2) begin
			r = CNT_W'(2);
		end else if (int'(req) > MAX_WINDOW) begin
			r = CNT_W'(MAX_WINDOW);
		end else begin
			r = CNT_W'(req);
		end
		return r;
	endfunction

	function automatic logic abs_lt(input logic signed [TST_W-1:0] d,
		input logic [TST_W-1:0] lim);
		logic [TST_W-1:0] mag;
		mag = d[TST_W-1] ? TST_W'(-d) : TST_W'(d);
		return mag < lim;
	endfunction

endpackage
`default_nettype wire

>>> design/stld_mul.sv
// Shared signed multiplier: one 8-bit digit of the B operand per cycle.
`default_nettype none
module stld_mul (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  stld_pkg::acc_t                     a,
	input  logic signed [stld_pkg::MB_W-1:0]   b,
	output logic                               done,
	output stld_pkg::acc_t                     prod
);
	import stld_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [MCNT_W-1:0] cnt_q;
	logic [ACC_W-1:0]  aa_q;
	logic [MB_W-1:0]   bb_q;
	logic [ACC_W-1:0]  acc_q;
	logic              neg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + MCNT_W'(1);
				if (cnt_q == MCNT_W'(MB_DIG - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			aa_q  <= a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
			bb_q  <= b[MB_W-1] ? MB_W'(-b) : MB_W'(b);
			neg_q <= a[ACC_W-1] ^ b[MB_W-1];
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + aa_q * ACC_W'(bb_q[DIG_W-1:0]);
			aa_q  <= aa_q << DIG_W;
			bb_q  <= bb_q >> DIG_W;
		end
	end

	assign done = done_q;
	assign prod = neg_q ? -$signed(acc_q) : $signed(acc_q);

endmodule
`default_nettype wire

>>> design/stld_div.sv
// Shared signed divider: restoring, one quotient bit per cycle, truncating or floor.
`default_nettype none
module stld_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  stld_pkg::acc_t num,
	input  stld_pkg::acc_t den,
	input  logic           floor_mode,
	output logic           done,
	output stld_pkg::acc_t quo
);
	import stld_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [ACC_W-1:0]  nq_q;
	logic [ACC_W-1:0]  rem_q;
	logic [ACC_W-1:0]  dd_q;
	logic              neg_q;
	logic              floor_q;
	logic [ACC_W-1:0]  rem_sh;
	logic              qbit;
	acc_t              qneg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DCNT_W'(1);
				if (cnt_q == DCNT_W'(ACC_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		rem_sh = {rem_q[ACC_W-2:0], nq_q[ACC_W-1]};
		qbit   = (rem_sh >= dd_q);
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nq_q    <= num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
			dd_q    <= den[ACC_W-1] ? ACC_W'(-den) : ACC_W'(den);
			rem_q   <= '0;
			neg_q   <= num[ACC_W-1] ^ den[ACC_W-1];
			floor_q <= floor_mode;
		end else if (busy_q) begin
			rem_q <= qbit ? rem_sh - dd_q : rem_sh;
			nq_q  <= {nq_q[ACC_W-2:0], qbit};
		end
	end

	// round toward minus infinity when asked and the remainder is not zero
	assign qneg = -$signed(nq_q) - ((floor_q && (rem_q != '0)) ? acc_t'(1) : acc_t'(0));
	assign quo  = neg_q ? qneg : $signed(nq_q);
	assign done = done_q;

endmodule
`default_nettype wire

>>> design/stld_ctrl.sv
// Controller: sequences the window walk, the regression and the tests.
`default_nettype none
module stld_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  stld_pkg::sts_t sts,
	output stld_pkg::cmd_t cmd
);
	import stld_pkg::*;

	state_t state_q, state_d;
	mop_t   mop_q, mop_d;
	dop_t   dop_q, dop_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mop_q   <= MOP_DYDX;
			dop_q   <= DOP_SLOPE;
		end else begin
			state_q <= state_d;
			mop_q   <= mop_d;
			dop_q   <= dop_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		mop_d    = mop_q;
		dop_d    = dop_q;
		s_tready = 1'b0;
		cmd      = '0;
		cmd.mop  = mop_q;
		cmd.dop  = dop_q;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.full) begin
					cmd.clr_sums = 1'b1;
					state_d      = ST_SUM_RD;
				end else begin
					state_d = ST_EST_WR;
				end
			end
			ST_SUM_RD: state_d = ST_SUM_DAT;
			ST_SUM_DAT: begin
				cmd.sum_dat = 1'b1;
				mop_d       = MOP_DYDX;
				state_d     = ST_MUL_GO;
			end
			ST_MUL_GO: begin
				cmd.mul_start = 1'b1;
				state_d       = ST_MUL_WAIT;
			end
			ST_MUL_WAIT: begin
				if (sts.mul_done) begin
					state_d = ST_MUL_GO;
					case (mop_q)
						MOP_DYDX: mop_d = MOP_DXDX;
						MOP_DXDX: begin
							if (sts.k_sum_last) begin
								mop_d = MOP_RSXY;
							end else begin
								cmd.inc_k = 1'b1;
								state_d   = ST_SUM_RD;
							end
						end
						MOP_RSXY: mop_d = MOP_SXSY;
						MOP_SXSY: mop_d = MOP_RSXX;
						MOP_RSXX: mop_d = MOP_SXSX;
						MOP_SXSX: state_d = ST_DEN_CHK;
						MOP_RADV: mop_d = MOP_SLOPE;
						MOP_SLOPE: begin
							dop_d   = DOP_EST;
							state_d = ST_DIV_GO;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_DEN_CHK: begin
				if (sts.den_zero) begin
					state_d = ST_EST_WR;
				end else begin
					dop_d   = DOP_SLOPE;
					state_d = ST_DIV_GO;
				end
			end
			ST_DIV_GO: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (sts.div_done) begin
					if (dop_q == DOP_SLOPE) begin
						mop_d   = MOP_RADV;
						state_d = ST_MUL_GO;
					end else begin
						state_d = ST_EST_WR;
					end
				end
			end
			ST_EST_WR: begin
				cmd.est_wr = 1'b1;
				if (sts.full) begin
					cmd.t_init = 1'b1;
					state_d    = ST_T_RD;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_T_RD: state_d = ST_T_CHK;
			ST_T_CHK: begin
				cmd.t_chk = 1'b1;
				if (sts.k_t_last) begin
					state_d = ST_OUT;
				end else begin
					cmd.inc_k = 1'b1;
					state_d   = ST_T_RD;
				end
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

>>> design/stld_dp.sv
// Datapath: config registers, event windows, sums, regression, tests and output register.
`default_nettype none
module stld_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [stld_pkg::REG_IDX_W-1:0]        cfg_index,
	input  logic [stld_pkg::CFG_W-1:0]            cfg_wdata,
	input  logic [stld_pkg::NUM_W-1:0]            swap_number,
	input  logic [stld_pkg::TIME_W-1:0]           swap_time_ns,
	input  logic [stld_pkg::TIME_W-1:0]           user_next_estimate_ns,
	input  logic                                  has_user_estimate,
	input  stld_pkg::cmd_t                        cmd,
	output stld_pkg::sts_t                        sts,
	input  logic                                  m_tready,
	output logic                                  m_tvalid,
	output logic                                  synchronized,
	output logic                                  window_full,
	output logic [stld_pkg::TIME_W-1:0]           model_next_estimate_ns,
	output logic signed [stld_pkg::OUT_W-1:0]     model_slope_q16
);
	import stld_pkg::*;

	cfg_t cfg_q;

	logic [NUM_W-1:0]  num_mem [MAX_WINDOW];
	logic [TIME_W-1:0] time_mem [MAX_WINDOW];
	logic [TIME_W-1:0] ue_mem [MAX_WINDOW];
	logic [TIME_W-1:0] me_mem [MAX_WINDOW];

	logic [IDX_W-1:0] wp_q, newest_q, k_q, addr_a, addr_b;
	logic [CNT_W-1:0] fill_q, r;
	logic             utd_q, ready_q, sync_q, out_valid_q;

	logic [NUM_W-1:0]  num_q, num_rd_q;
	logic [TIME_W-1:0] t_q, ta_rd_q, tb_rd_q, ue_rd_q, me_rd_q, est_q;

	logic signed [NUM_W:0]      dx_q, dx_d;
	logic signed [TIME_W:0]     dy_q, dy_d;
	logic signed [SX_W-1:0]     sx_q;
	logic signed [SY_W-1:0]     sy_q;
	logic [RADV_W-1:0]          radv_q;
	logic signed [OUT_W-1:0]    slope_q;
	acc_t                       sxy_q, sxx_q, p1_q, nn_q, dd_q, enum_q;

	mop_t mop_q;
	dop_t dop_q;

	acc_t                    mul_a, mul_prod, div_num, div_den, div_quo, e_sum;
	logic signed [MB_W-1:0]  mul_b;
	logic                    mul_done, div_done;
	logic                    pass_pair, slope_ok, sync_fin;

	logic              o_sync_q, o_full_q;
	logic [TIME_W-1:0] o_est_q;
	logic signed [OUT_W-1:0] o_slope_q;

	// ring slots of the current window, oldest first
	assign r      = win_len(cfg_q.req_swaps);
	assign addr_a = wp_q - r[IDX_W-1:0] + k_q;
	assign addr_b = addr_a + IDX_W'(1);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.req_swaps     <= REQ_W'(2);
			cfg_q.nominal       <= PER_W'(16666667);
			cfg_q.tolerance     <= '0;
			cfg_q.advance       <= ADV_W'(1);
			cfg_q.en_interval   <= 1'b1;
			cfg_q.en_user       <= 1'b0;
			cfg_q.en_slope      <= 1'b0;
			cfg_q.en_model_pred <= 1'b0;
			wp_q        <= '0;
			fill_q      <= '0;
			utd_q       <= 1'b0;
			k_q         <= '0;
			ready_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_REQ_SWAPS:     cfg_q.req_swaps     <= cfg_wdata[REQ_W-1:0];
					REG_NOMINAL:       cfg_q.nominal       <= cfg_wdata[PER_W-1:0];
					REG_TOLERANCE:     cfg_q.tolerance     <= cfg_wdata[PER_W-1:0];
					REG_ADVANCE:       cfg_q.advance       <= cfg_wdata[ADV_W-1:0];
					REG_EN_INTERVAL:   cfg_q.en_interval   <= cfg_wdata[0];
					REG_EN_USER:       cfg_q.en_user       <= cfg_wdata[0];
					REG_EN_SLOPE:      cfg_q.en_slope      <= cfg_wdata[0];
					REG_EN_MODEL_PRED: cfg_q.en_model_pred <= cfg_wdata[0];
					default: ;
				endcase
			end
			if (cmd.accept) begin
				wp_q    <= wp_q + IDX_W'(1);
				ready_q <= 1'b0;
				if (int'(fill_q) < MAX_WINDOW) begin
					fill_q <= fill_q + CNT_W'(1);
				end
				if (!has_user_estimate) begin
					utd_q <= 1'b1;
				end
			end
			if (cmd.clr_sums || cmd.t_init) begin
				k_q <= '0;
			end else if (cmd.inc_k) begin
				k_q <= k_q + IDX_W'(1);
			end
			if (div_done && dop_q == DOP_EST) begin
				ready_q <= 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// event windows
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			num_mem[wp_q]  <= swap_number;
			time_mem[wp_q] <= swap_time_ns;
			ue_mem[wp_q]   <= has_user_estimate ? user_next_estimate_ns : '0;
		end
		if (cmd.est_wr) begin
			me_mem[newest_q] <= ready_q ? est_q : '0;
		end
		num_rd_q <= num_mem[addr_a];
		ta_rd_q  <= time_mem[addr_a];
		tb_rd_q  <= time_mem[addr_b];
		ue_rd_q  <= ue_mem[addr_a];
		me_rd_q  <= me_mem[addr_a];
	end

	assign dx_d = $signed({1'b0, num_rd_q}) - $signed({1'b0, num_q});
	assign dy_d = $signed({1'b0, ta_rd_q}) - $signed({1'b0, t_q});

	// multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mop)
			MOP_DYDX:  begin mul_a = ACC_W'(dy_q);    mul_b = MB_W'(dx_q); end
			MOP_DXDX:  begin mul_a = ACC_W'(dx_q);    mul_b = MB_W'(dx_q); end
			MOP_RSXY:  begin mul_a = sxy_q;           mul_b = MB_W'(r); end
			MOP_SXSY:  begin mul_a = ACC_W'(sy_q);    mul_b = MB_W'(sx_q); end
			MOP_RSXX:  begin mul_a = sxx_q;           mul_b = MB_W'(r); end
			MOP_SXSX:  begin mul_a = ACC_W'(sx_q);    mul_b = MB_W'(sx_q); end
			MOP_RADV:  begin mul_a = ACC_W'(r);       mul_b = MB_W'(cfg_q.advance); end
			MOP_SLOPE: begin
				mul_a = ACC_W'(slope_q);
				mul_b = $signed(MB_W'(radv_q) - MB_W'(sx_q));
			end
			default: ;
		endcase
	end

	// divider operands: slope = (N << F) / D, estimate offset = floor(E / (R << F))
	always_comb begin
		if (cmd.dop == DOP_SLOPE) begin
			div_num = nn_q <<< SLOPE_FRAC;
			div_den = dd_q;
		end else begin
			div_num = enum_q;
			div_den = ACC_W'(r) <<< SLOPE_FRAC;
		end
	end

	stld_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	stld_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (cmd.div_start),
		.num        (div_num),
		.den        (div_den),
		.floor_mode (cmd.dop == DOP_EST),
		.done       (div_done),
		.quo        (div_quo)
	);

	assign e_sum = ACC_W'(t_q) + div_quo;

	// regression registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			num_q    <= swap_number;
			t_q      <= swap_time_ns;
			newest_q <= wp_q;
			est_q    <= '0;
			slope_q  <= '0;
		end
		if (cmd.clr_sums) begin
			sx_q  <= '0;
			sy_q  <= '0;
			sxy_q <= '0;
			sxx_q <= '0;
		end
		if (cmd.sum_dat) begin
			dx_q <= dx_d;
			dy_q <= dy_d;
			sx_q <= sx_q + SX_W'(dx_d);
			sy_q <= sy_q + SY_W'(dy_d);
		end
		if (cmd.mul_start) begin
			mop_q <= cmd.mop;
		end
		if (cmd.div_start) begin
			dop_q <= cmd.dop;
		end
		if (mul_done) begin
			case (mop_q)
				MOP_DYDX:  sxy_q  <= sxy_q + mul_prod;
				MOP_DXDX:  sxx_q  <= sxx_q + mul_prod;
				MOP_RSXY:  p1_q   <= mul_prod;
				MOP_SXSY:  nn_q   <= p1_q - mul_prod;
				MOP_RSXX:  p1_q   <= mul_prod;
				MOP_SXSX:  dd_q   <= p1_q - mul_prod;
				MOP_RADV:  radv_q <= mul_prod[RADV_W-1:0];
				MOP_SLOPE: enum_q <= (ACC_W'(sy_q) <<< SLOPE_FRAC) + mul_prod;
				default: ;
			endcase
		end
		if (div_done) begin
			if (dop_q == DOP_SLOPE) begin
				// saturate to the signed output width
				if (div_quo[ACC_W-1:OUT_W-1] == '0 || div_quo[ACC_W-1:OUT_W-1] == '1) begin
					slope_q <= div_quo[OUT_W-1:0];
				end else if (div_quo[ACC_W-1]) begin
					slope_q <= {1'b1, {(OUT_W-1){1'b0}}};
				end else begin
					slope_q <= {1'b0, {(OUT_W-1){1'b1}}};
				end
			end else begin
				// clamp the estimate to the time range
				if (e_sum[ACC_W-1]) begin
					est_q <= '0;
				end else if (e_sum[ACC_W-1:TIME_W] != '0) begin
					est_q <= '1;
				end else begin
					est_q <= e_sum[TIME_W-1:0];
				end
			end
		end
		if (cmd.t_init) begin
			sync_q <= 1'b1;
		end else if (cmd.t_chk && !pass_pair) begin
			sync_q <= 1'b0;
		end
	end

	// tests on one pair of neighboring events
	always_comb begin
		pass_pair = 1'b1;
		if (cfg_q.en_interval && !abs_lt($signed(TST_W'(tb_rd_q) - TST_W'(ta_rd_q)
			- TST_W'(cfg_q.nominal)), TST_W'(cfg_q.tolerance))) begin
			pass_pair = 1'b0;
		end
		if (cfg_q.en_user && !utd_q && !abs_lt($signed(TST_W'(ue_rd_q) - TST_W'(tb_rd_q)),
			TST_W'(cfg_q.tolerance))) begin
			pass_pair = 1'b0;
		end
		if (cfg_q.en_model_pred && !abs_lt($signed(TST_W'(me_rd_q) - TST_W'(tb_rd_q)),
			TST_W'(cfg_q.tolerance))) begin
			pass_pair = 1'b0;
		end
	end

	assign slope_ok = abs_lt($signed(TST_W'(slope_q)
		- TST_W'({cfg_q.nominal, {SLOPE_FRAC{1'b0}}})),
		TST_W'({cfg_q.tolerance, {SLOPE_FRAC{1'b0}}}));

	assign sync_fin = sts.full && sync_q
		&& !((cfg_q.en_slope || cfg_q.en_model_pred) && !ready_q)
		&& !(cfg_q.en_slope && ready_q && !slope_ok);

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			o_sync_q  <= sync_fin;
			o_full_q  <= sts.full;
			o_est_q   <= est_q;
			o_slope_q <= slope_q;
		end
	end

	assign sts.full       = fill_q >= r;
	assign sts.den_zero   = (dd_q == '0);
	assign sts.k_sum_last = (CNT_W'(k_q) == r - CNT_W'(1));
	assign sts.k_t_last   = (CNT_W'(k_q) == r - CNT_W'(2));
	assign sts.mul_done   = mul_done;
	assign sts.div_done   = div_done;
	assign sts.out_free   = !out_valid_q || m_tready;

	assign m_tvalid               = out_valid_q;
	assign synchronized           = o_sync_q;
	assign window_full            = o_full_q;
	assign model_next_estimate_ns = o_est_q;
	assign model_slope_q16        = o_slope_q;

endmodule
`default_nettype wire

>>> design/swap_timing_lock_detector_unit.sv
// Top level of the swap timing lock detector.
//
//  channel  dir  handshake          payload (lowest bit first)
//  s_*      in   tvalid/tready      tdata: swap_number, swap_time_ns, user_next_estimate_ns
//                                   tuser: has_user_estimate
//  m_*      out  tvalid/tready      tdata: model_next_estimate_ns, model_slope_q16
//                                   tuser: synchronized, window_full
//  cfg_*    in   we, no wait        index selects one of eight registers
//
// Without a full window an event goes from the check to the estimate write and the output
// register. With a full window of R events each event is walked through the shared
// multiplier (one 8-bit digit per cycle, two products per event) and the serial divider runs
// 112 steps twice, for slope and estimate, or not at all when all swap numbers are equal.
// Reset clears control, configuration and fill state; window contents stay undefined.
// One event is in flight at a time; the next is taken as soon as its result sits in
// the output register, even while that register is stalled.
`default_nettype none
module swap_timing_lock_detector_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	// stream in
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [127:0]                       s_tdata,   // swap_number, swap_time_ns, user_next_estimate_ns
	input  logic                               s_tuser,   // has_user_estimate
	// stream out
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [95:0]                        m_tdata,   // model_next_estimate_ns, model_slope_q16
	output logic [1:0]                         m_tuser,   // synchronized, window_full
	// configuration writes
	input  logic                               cfg_we,
	input  logic [stld_pkg::REG_IDX_W-1:0]     cfg_index,
	input  logic [stld_pkg::CFG_W-1:0]         cfg_wdata
);
	import stld_pkg::*;

	cmd_t cmd;
	sts_t sts;

	logic [TIME_W-1:0]       est;
	logic signed [OUT_W-1:0] slope;
	logic                    sync, full;

	// sequence one event at a time
	stld_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// unpack the input transfer straight into the datapath
	stld_dp u_dp (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.cfg_we                 (cfg_we),
		.cfg_index              (cfg_index),
		.cfg_wdata              (cfg_wdata),
		.swap_number            (s_tdata[NUM_W-1:0]),
		.swap_time_ns           (s_tdata[NUM_W+TIME_W-1:NUM_W]),
		.user_next_estimate_ns  (s_tdata[NUM_W+2*TIME_W-1:NUM_W+TIME_W]),
		.has_user_estimate      (s_tuser),
		.cmd                    (cmd),
		.sts                    (sts),
		.m_tready               (m_tready),
		.m_tvalid               (m_tvalid),
		.synchronized           (sync),
		.window_full            (full),
		.model_next_estimate_ns (est),
		.model_slope_q16        (slope)
	);

	// pack the output transfer
	assign m_tdata = {slope, est};
	assign m_tuser = {full, sync};

endmodule
`default_nettype wire

>>> design/stld_checker.sv
// Port-level checker of the swap lock detector, bound to the top level.
`default_nettype none
`include "swap_timing_lock_detector_unit_assert.svh"
module stld_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [95:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// a stalled result stays offered
	`STLD_ASSERT_NXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)
	// a stalled result keeps its data
	`STLD_ASSERT_NXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))
	// lock is never reported before the window is full
	`STLD_ASSERT_IMP(a_sync_needs_full, m_tvalid && m_tuser[0], m_tuser[1])
	// with no full window the model reports zero estimate and slope
	`STLD_ASSERT_IMP(a_model_zero, m_tvalid && !m_tuser[1], m_tdata == '0)

endmodule

bind swap_timing_lock_detector_unit stld_checker u_stld_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire
